### hw/rtl/csort_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csort_pkg
// Shared types for the counting sort engine: transaction payloads and the
// control word of the histogram update unit.
// ----------------------------------------------------------------------------
package csort_pkg;

  localparam int KEY_W = 5;

  typedef struct packed {
    logic [KEY_W-1:0] key_value;
    logic             batch_end;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] sorted_key;
    logic             final_flag;
    logic             overflow_flag;
  } out_item_t;

  typedef enum logic {
    HIST_INC,
    HIST_DEC
  } hist_op_t;

  typedef struct packed {
    logic     en;
    hist_op_t op;
  } hist_ctrl_t;

endpackage

### hw/rtl/csort_hist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csort_hist
// Histogram of per-key counts with one shared increment/decrement unit that
// performs a read-modify-write on the addressed entry.
// ----------------------------------------------------------------------------
module csort_hist #(
  parameter int DEPTH = 32,
  parameter int IDX_W = 5,
  parameter int CNT_W = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  csort_pkg::hist_ctrl_t ctrl,
  input  logic [IDX_W-1:0]    addr,
  output logic [CNT_W-1:0]    count
);

  logic [CNT_W-1:0] hist [DEPTH];
  logic [CNT_W-1:0] count_next;

  always_comb begin
    count = hist[addr];
    if (ctrl.op == csort_pkg::HIST_INC) begin
      count_next = count + CNT_W'(1);
    end else begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        hist[i] <= '0;
      end
    end else if (ctrl.en) begin
      hist[addr] <= count_next;
    end
  end

  a_no_dec_at_zero: assert property (@(posedge clk) disable iff (rst)
    ctrl.en && ctrl.op == csort_pkg::HIST_DEC |-> count != '0)
    else $error("Histogram entry decremented below zero.");

  a_no_inc_at_max: assert property (@(posedge clk) disable iff (rst)
    ctrl.en && ctrl.op == csort_pkg::HIST_INC |-> count != '1)
    else $error("Histogram entry incremented past its maximum.");

  a_write_lands: assert property (@(posedge clk) disable iff (rst)
    ctrl.en |=> hist[$past(addr)] == $past(count_next))
    else $error("Histogram write did not take effect.");

endmodule

### hw/rtl/csort_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csort_seq
// Sequencer of the counting sort engine: loads keys into the histogram, then
// scans it from the smallest key upward and drives the result register.
// ----------------------------------------------------------------------------
module csort_seq #(
  parameter int NUM_KEYS  = 32,
  parameter int MAX_ITEMS = 64,
  parameter int IDX_W     = 5,
  parameter int CNT_W     = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  csort_pkg::in_item_t   item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output csort_pkg::out_item_t  result,
  output csort_pkg::hist_ctrl_t hist_ctrl,
  output logic [IDX_W-1:0]      hist_addr,
  input  logic [CNT_W-1:0]      hist_count
);

  typedef enum logic {
    ST_LOAD,
    ST_SCAN
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] item_count;
  logic             dropped_mark;
  logic [IDX_W-1:0] scan_idx;

  logic take;
  logic in_range;
  logic full;
  logic out_free;
  logic emit;

  always_comb begin
    item_ready = (state == ST_LOAD);
    take       = item_valid && item_ready;
    in_range   = 32'(item.key_value) < NUM_KEYS;
    full       = (item_count == CNT_W'(MAX_ITEMS));
    out_free   = !result_valid || result_ready;
    emit       = 1'b0;
    hist_ctrl.en = 1'b0;
    hist_ctrl.op = csort_pkg::HIST_INC;
    hist_addr    = scan_idx;
    if (state == ST_LOAD) begin
      hist_addr = item.key_value[IDX_W-1:0];
      if (take && in_range && !full) begin
        hist_ctrl.en = 1'b1;
      end
    end else begin
      if (item_count != '0 && hist_count != '0 && out_free) begin
        emit         = 1'b1;
        hist_ctrl.en = 1'b1;
        hist_ctrl.op = csort_pkg::HIST_DEC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      item_count   <= '0;
      dropped_mark <= 1'b0;
      scan_idx     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (take) begin
            if (in_range) begin
              if (full) begin
                dropped_mark <= 1'b1;
              end else begin
                item_count <= item_count + CNT_W'(1);
              end
            end
            if (item.batch_end) begin
              state    <= ST_SCAN;
              scan_idx <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (item_count == '0) begin
            state        <= ST_LOAD;
            dropped_mark <= 1'b0;
            scan_idx     <= '0;
          end else if (hist_count == '0) begin
            scan_idx <= scan_idx + IDX_W'(1);
          end else if (emit) begin
            result.sorted_key    <= csort_pkg::KEY_W'(scan_idx);
            result.final_flag    <= (item_count == CNT_W'(1));
            result.overflow_flag <= (item_count == CNT_W'(1)) && dropped_mark;
            item_count           <= item_count - CNT_W'(1);
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(item_count) <= MAX_ITEMS)
    else $error("Item count exceeds batch capacity.");

  a_final_ends_scan: assert property (@(posedge clk) disable iff (rst)
    emit && item_count == CNT_W'(1) |=> state == ST_SCAN && item_count == '0 ##1
    state == ST_LOAD && !dropped_mark)
    else $error("Scan did not close after the final transaction.");

  a_overflow_only_final: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.overflow_flag |-> result.final_flag)
    else $error("Overflow flag raised on a non-final transaction.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> !result_valid || result_ready)
    else $error("Result register overwritten before it was taken.");

endmodule

### hw/rtl/counting_sort_engine_top.sv
`timescale 1ns / 1ps
// Loading: a key without batch_end is taken at one transaction per cycle.
// A key with batch_end starts a scan from histogram entry 0 up to the highest counted
// key: zero entries are stepped over, each count is emitted as a key while the result
// register is free, and the scan then closes; the single histogram update unit makes
// every update. An empty batch closes without a key. No input is taken during the scan.
// Reset (rst, synchronous, active high) clears the histogram, counters, drop mark and result_valid.
// ----------------------------------------------------------------------------
// counting_sort_engine_top
// Counting sort of small unsigned keys with a histogram sized by key range.
// ----------------------------------------------------------------------------
module counting_sort_engine_top #(
  parameter int NUM_KEYS  = 32,
  parameter int MAX_ITEMS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  csort_pkg::in_item_t  item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output csort_pkg::out_item_t result
);

  localparam int HIST_DEPTH = (NUM_KEYS < (1 << csort_pkg::KEY_W)) ?
                              NUM_KEYS : (1 << csort_pkg::KEY_W);
  localparam int IDX_W      = $clog2(HIST_DEPTH);
  localparam int CNT_W      = $clog2(MAX_ITEMS + 1);

  csort_pkg::hist_ctrl_t hist_ctrl;
  logic [IDX_W-1:0]      hist_addr;
  logic [CNT_W-1:0]      hist_count;

  csort_seq #(
    .NUM_KEYS  (NUM_KEYS),
    .MAX_ITEMS (MAX_ITEMS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .hist_ctrl    (hist_ctrl),
    .hist_addr    (hist_addr),
    .hist_count   (hist_count)
  );

  csort_hist #(
    .DEPTH (HIST_DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_hist (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (hist_ctrl),
    .addr  (hist_addr),
    .count (hist_count)
  );

endmodule
